@@ rtl/axis_deadzone_calibrator_assert.svh @@
// Assertion macros for the axis deadzone calibrator.
// Used by the top level; expects clk_i and rst_ni in the including scope.
`ifndef AXIS_DEADZONE_CALIBRATOR_ASSERT_SVH
`define AXIS_DEADZONE_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ADC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/adc_pkg.sv @@
// Shared types and constants of the axis deadzone calibrator.
// No dependencies; imported by every module of the block.
package adc_pkg;

  localparam int unsigned VAL_W     = 19;  // signed working width of raw values
  localparam int unsigned MAG_W     = 18;  // magnitude of a raw difference
  localparam int unsigned SCALE_W   = 17;  // output span of one mapping
  localparam int unsigned PROD_W    = MAG_W + SCALE_W;
  localparam int unsigned QUO_W     = 17;  // quotient bits kept before saturation
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [15:0] FULL_SCALE = 16'hFFFF;
  localparam logic [15:0] HALF_SCALE = 16'h7FFF;

  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_POINT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ID      = 3'd5;

  typedef struct packed {
    logic [15:0] range_max;
    logic [15:0] range_min;
    logic [15:0] dead_band;
    logic [15:0] center_point;
    logic        trigger_mode;
    logic [7:0]  axis_id;
  } cfg_t;

  // Operands of one linear map, or a result known without dividing.
  typedef struct packed {
    logic                    direct;
    logic [15:0]             direct_val;
    logic signed [VAL_W-1:0] diff;
    logic signed [VAL_W-1:0] span;
    logic [SCALE_W-1:0]      scale;
    logic [15:0]             base;
  } map_op_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [QUO_W-1:0] quo;
  } div_res_t;

endpackage

@@ rtl/axis_deadzone_calibrator.sv @@
// Top level of the axis deadzone calibrator: registers, sequencer, output stage.
// Depends on adc_pkg, adc_map_setup, adc_divider and the assertion header.
//
// Usage: samples arrive on the in channel (in_valid_i/in_ready_o) with
// sample_i and force_report_i. A request whose sample equals the last
// reported one, without force_report_i, is accepted and gives no
// event. Any other request gives one event on the out channel
// (out_valid_o/out_ready_i) with event_id_o, raw_value_o and calibrated_o.
// Configuration writes use cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; the port is always ready and writes to unknown indexes are
// dropped. Write it only while the block is idle.
// Sequencing: a decoded result (deadzone or mode) goes straight to the finish
// step; a mapped result passes the multiply, start and divide-wait steps first,
// the divider making one quotient bit per cycle for 17 bits, or none when the
// quotient is too wide. in_ready_o stays low meanwhile, so no new request is
// taken until the result has left the finish step.
// An output register parts the channels: the next request is accepted while
// an event waits, and a finished result waits in the sequencer while the
// receiver stalls. Reset restores the register defaults, clears the
// remembered sample to zero and empties the output stage.
module axis_deadzone_calibrator
  import adc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          sample_i,
  input  logic                 force_report_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           event_id_o,
  output logic [15:0]          raw_value_o,
  output logic [15:0]          calibrated_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIVW = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  cfg_t        cfg_q;
  logic [2:0]  state_q, state_d;
  logic [15:0] prev_q;
  map_op_t     op, op_q;
  logic [15:0] raw_q, res_q;
  logic [7:0]  id_q;
  logic        neg_q;
  logic [PROD_W-1:0] prod_q;
  logic [MAG_W-1:0]  span_mag;
  logic [MAG_W-1:0]  diff_mag;
  logic        in_acc, emit, fin_load, div_start;
  div_res_t    div_res;
  logic signed [VAL_W-1:0] q_signed, sum;
  logic [15:0] div_result;
  logic        out_valid_q;
  logic [7:0]  out_id_q;
  logic [15:0] out_raw_q, out_cal_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign emit        = (sample_i != prev_q) || force_report_i;
  assign fin_load    = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign div_start   = (state_q == S_DIVS);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_max    <= FULL_SCALE;
      cfg_q.range_min    <= '0;
      cfg_q.dead_band    <= '0;
      cfg_q.center_point <= HALF_SCALE;
      cfg_q.trigger_mode <= 1'b0;
      cfg_q.axis_id      <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_RANGE_MAX:    cfg_q.range_max    <= cfg_data_i;
        REG_RANGE_MIN:    cfg_q.range_min    <= cfg_data_i;
        REG_DEAD_BAND:    cfg_q.dead_band    <= cfg_data_i;
        REG_CENTER_POINT: cfg_q.center_point <= cfg_data_i;
        REG_TRIGGER_MODE: cfg_q.trigger_mode <= cfg_data_i[0];
        REG_AXIS_ID:      cfg_q.axis_id      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  adc_map_setup u_setup (
    .sample_i (sample_i),
    .cfg_i    (cfg_q),
    .op_o     (op)
  );

  // Magnitudes for the unsigned multiply and divide; the sign is carried apart.
  assign diff_mag = op_q.diff[VAL_W-1] ? MAG_W'(-op_q.diff) : op_q.diff[MAG_W-1:0];
  assign span_mag = op_q.span[VAL_W-1] ? MAG_W'(-op_q.span) : op_q.span[MAG_W-1:0];

  adc_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q),
    .divisor_i  (span_mag),
    .res_o      (div_res)
  );

  // Truncated quotient applied to the base, then clamped to 16 bits. A
  // quotient beyond QUO_W bits always lands outside the output range.
  always_comb begin
    q_signed = signed'({{(VAL_W-QUO_W){1'b0}}, div_res.quo});
    if (neg_q) q_signed = -q_signed;
    sum = signed'({{(VAL_W-16){1'b0}}, op_q.base}) + q_signed;
    if (div_res.ovf) begin
      div_result = neg_q ? 16'h0000 : FULL_SCALE;
    end else if (sum < 0) begin
      div_result = 16'h0000;
    end else if (sum > signed'({{(VAL_W-16){1'b0}}, FULL_SCALE})) begin
      div_result = FULL_SCALE;
    end else begin
      div_result = sum[15:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && emit) state_d = op.direct ? S_FIN : S_MUL;
      end
      S_MUL:  state_d = S_DIVS;
      S_DIVS: state_d = S_DIVW;
      S_DIVW: begin
        if (div_res.done) state_d = S_FIN;
      end
      S_FIN: begin
        if (fin_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && emit) prev_q <= sample_i;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working payload of the request in flight.
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      op_q  <= op;
      raw_q <= sample_i;
      id_q  <= cfg_q.axis_id;
      res_q <= op.direct_val;
    end
    if (state_q == S_MUL) begin
      prod_q <= PROD_W'(diff_mag * op_q.scale);
      neg_q  <= op_q.diff[VAL_W-1] ^ op_q.span[VAL_W-1];
    end
    if ((state_q == S_DIVW) && div_res.done) res_q <= div_result;
    if (fin_load) begin
      out_id_q  <= id_q;
      out_raw_q <= raw_q;
      out_cal_q <= res_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_id_o   = out_id_q;
  assign raw_value_o  = out_raw_q;
  assign calibrated_o = out_cal_q;

`include "axis_deadzone_calibrator_assert.svh"

  `ADC_ASSERT_NXT(a_emit_busy, in_acc && emit, !in_ready_o, "block still ready after an event request")
  `ADC_ASSERT_NXT(a_skip_ready, in_acc && !emit, in_ready_o, "request without event left block busy")
  `ADC_ASSERT_IMP(a_done_in_wait, div_res.done, state_q == S_DIVW, "divider finished outside its wait step")
  `ADC_ASSERT_NXT(a_fin_loads, fin_load, out_valid_o && in_ready_o, "finished result not presented")

endmodule

@@ rtl/adc_map_setup.sv @@
// Mode and deadzone decode: selects the linear-map operands for one sample.
// Depends on adc_pkg.
module adc_map_setup
  import adc_pkg::*;
(
  input  logic [15:0] sample_i,
  input  cfg_t        cfg_i,
  output map_op_t     op_o
);

  logic signed [VAL_W-1:0] v, hi, lo, dz, c, a, b, vv;
  logic                    inv;

  always_comb begin
    v   = signed'({3'b000, sample_i});
    hi  = signed'({3'b000, cfg_i.range_max});
    lo  = signed'({3'b000, cfg_i.range_min});
    dz  = signed'({3'b000, cfg_i.dead_band});
    c   = signed'({3'b000, cfg_i.center_point});
    inv = cfg_i.range_min > cfg_i.range_max;

    op_o.direct     = 1'b0;
    op_o.direct_val = '0;
    op_o.scale      = {1'b0, FULL_SCALE};
    op_o.base       = '0;
    a  = lo;
    b  = hi;
    vv = v;

    if (cfg_i.trigger_mode) begin
      if (inv) begin
        a = lo - dz;
        if (v > a) op_o.direct = 1'b1;
        vv = (v < hi) ? hi : v;
      end else begin
        a = lo + dz;
        if (v < a) op_o.direct = 1'b1;
        vv = (v > hi) ? hi : v;
      end
    end else if (v < c) begin
      if ((c - v) < dz) begin
        op_o.direct     = 1'b1;
        op_o.direct_val = HALF_SCALE;
      end else if (inv) begin
        a          = c - dz;
        op_o.base  = HALF_SCALE;
        op_o.scale = {1'b0, FULL_SCALE} - {1'b0, HALF_SCALE};
      end else begin
        b          = c - dz;
        op_o.scale = {1'b0, HALF_SCALE};
      end
    end else begin
      if ((v - c) < dz) begin
        op_o.direct     = 1'b1;
        op_o.direct_val = HALF_SCALE;
      end else if (inv) begin
        b          = c + dz;
        op_o.scale = {1'b0, HALF_SCALE};
      end else begin
        a          = c + dz;
        op_o.base  = HALF_SCALE;
        op_o.scale = {1'b0, FULL_SCALE} - {1'b0, HALF_SCALE};
      end
    end

    op_o.diff = vv - a;
    op_o.span = b - a;

    // A zero span answers the lower output bound.
    if (!op_o.direct && (op_o.span == '0)) begin
      op_o.direct     = 1'b1;
      op_o.direct_val = op_o.base;
    end
  end

endmodule

@@ rtl/adc_divider.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on adc_pkg; flags quotients that do not fit in QUO_W bits.
module adc_divider
  import adc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [PROD_W-1:0] dividend_i,
  input  logic [MAG_W-1:0]  divisor_i,
  output div_res_t          res_o
);

  logic [PROD_W-1:0]   rem_q;
  logic [PROD_W-2:0]   dsh_q;
  logic [QUO_W-1:0]    quo_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q, done_q, ovf_q;
  logic                ovf_cmp, ge;

  assign ovf_cmp = dividend_i >= {divisor_i, {QUO_W{1'b0}}};
  assign ge      = rem_q >= {1'b0, dsh_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CNT_W'(QUO_W - 1);
        ovf_q  <= ovf_cmp;
        busy_q <= !ovf_cmp;
        done_q <= ovf_cmp;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i;
      dsh_q <= {divisor_i, {(QUO_W-1){1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - {1'b0, dsh_q};
      quo_q <= {quo_q[QUO_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quo  = quo_q;

endmodule

@@ tb/tb_axis_deadzone_calibrator.sv @@
// Self-checking testbench for axis_deadzone_calibrator: directed and random requests,
// random backpressure on both channels, and an event scoreboard with its own calibration.
// Depends on adc_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 100ps

module tb_axis_deadzone_calibrator;
  import adc_pkg::*;

  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 8;
  localparam int unsigned MAX_GAP       = 13;
  // Long enough to cover a mapped result with margin.
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASES        = 30;
  localparam int unsigned PHASE_ITEMS   = 55;
  localparam longint      LIMIT_CYCLES  = 500_000;

  // Indexes beyond the register file; the block must drop writes to them.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

  // One expected event on the out channel.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] raw;
    logic [15:0] cal;
  } axis_evt_t;

  // Scoreboard: keeps its own copy of the registers and of the remembered sample,
  // computes the event each accepted request causes and checks the events in order.
  class axis_evt_board;
    cfg_t        regs;
    logic [15:0] last_sample;
    axis_evt_t   pending_evts[$];
    int unsigned failures;

    function new();
      regs.range_max    = FULL_SCALE;
      regs.range_min    = '0;
      regs.dead_band    = '0;
      regs.center_point = HALF_SCALE;
      regs.trigger_mode = 1'b0;
      regs.axis_id      = '0;
      last_sample       = '0;
      failures          = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] d);
      case (idx)
        REG_RANGE_MAX:    regs.range_max    = d;
        REG_RANGE_MIN:    regs.range_min    = d;
        REG_DEAD_BAND:    regs.dead_band    = d;
        REG_CENTER_POINT: regs.center_point = d;
        REG_TRIGGER_MODE: regs.trigger_mode = d[0];
        REG_AXIS_ID:      regs.axis_id      = d[7:0];
        default: ;
      endcase
    endfunction

    // Straight-line map with the division truncated toward zero; a flat span
    // answers the lower output bound.
    function longint map_line(longint v, longint a, longint b, longint lo, longint hi);
      if (b == a) return lo;
      return lo + ((v - a) * (hi - lo)) / (b - a);
    endfunction

    function logic [15:0] clamp_u16(longint x);
      if (x > longint'(FULL_SCALE)) return FULL_SCALE;
      if (x < 0) return '0;
      return 16'(x);
    endfunction

    function logic [15:0] calibrate_position(logic [15:0] smp);
      longint v, hi, lo, dz, c, full, half;
      bit     inv;
      v    = longint'(smp);
      hi   = longint'(regs.range_max);
      lo   = longint'(regs.range_min);
      dz   = longint'(regs.dead_band);
      c    = longint'(regs.center_point);
      full = longint'(FULL_SCALE);
      half = longint'(HALF_SCALE);
      inv  = lo > hi;
      if (regs.trigger_mode) begin
        // The rest end moves by the deadzone; samples past full deflection are held.
        if (inv) begin
          lo = lo - dz;
          if (v > lo) return '0;
          if (v < hi) v = hi;
        end else begin
          lo = lo + dz;
          if (v < lo) return '0;
          if (v > hi) v = hi;
        end
        return clamp_u16(map_line(v, lo, hi, 0, full));
      end
      // Centered axis: each side maps to one half, swapped for an inverted range.
      if (v < c) begin
        if (c - v < dz) return HALF_SCALE;
        if (inv) return clamp_u16(map_line(v, c - dz, hi, half, full));
        return clamp_u16(map_line(v, lo, c - dz, 0, half));
      end
      if (v - c < dz) return HALF_SCALE;
      if (inv) return clamp_u16(map_line(v, lo, c + dz, 0, half));
      return clamp_u16(map_line(v, c + dz, hi, half, full));
    endfunction

    // An unchanged sample reports nothing unless forced.
    function void note_input(logic [15:0] smp, logic force_rpt);
      axis_evt_t e;
      if (smp == last_sample && !force_rpt) return;
      last_sample = smp;
      e.id  = regs.axis_id;
      e.raw = smp;
      e.cal = calibrate_position(smp);
      pending_evts.push_back(e);
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10) $display("%0t ns: %s", $time, msg);
    endfunction

    function void check_result(logic [7:0] id, logic [15:0] raw, logic [15:0] cal);
      axis_evt_t want;
      if (pending_evts.size() == 0) begin
        report($sformatf("event with none expected: id %0d raw %0d calibrated %0d",
                         id, raw, cal));
        return;
      end
      want = pending_evts.pop_front();
      if (id !== want.id || raw !== want.raw || cal !== want.cal)
        report($sformatf("event mismatch: expected id %0d raw %0d calibrated %0d, got id %0d raw %0d calibrated %0d",
                         want.id, want.raw, want.cal, id, raw, cal));
    endfunction

    function int unsigned pending();
      return pending_evts.size();
    endfunction
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0]          cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [15:0]          sample_i;
  logic                 force_report_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [7:0]           event_id_o;
  logic [15:0]          raw_value_o;
  logic [15:0]          calibrated_o;

  axis_evt_board sb = new();

  // Idle control shared by the sender, the receiver and the phase sequence.
  bit     src_calm  = 1'b0;
  bit     sink_calm = 1'b0;
  bit     hold_sink = 1'b0;
  longint cycle_count = 0;

  axis_deadzone_calibrator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .force_report_i (force_report_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_id_o     (event_id_o),
    .raw_value_o    (raw_value_o),
    .calibrated_o   (calibrated_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Run limit, far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("axis_deadzone_calibrator verification failed");
      $finish;
    end
  end

  // Every event accepted on the out channel is checked against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(event_id_o, raw_value_o, calibrated_o);
  end

  // Receiver: stalls a random number of cycles before each event, or not at all in
  // calm phases. When asked, it holds off for a long stretch so that the output
  // register and the sequencer fill and the block stops taking requests.
  initial begin : sink_proc
    int unsigned stall;
    out_ready_i = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_sink) begin
        stall     = HOLD_CYCLES;
        hold_sink = 1'b0;
      end else begin
        stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Offers one request after a random gap and returns at the edge it is accepted.
  // Valid stays high afterwards so back-to-back requests need no extra edge.
  task automatic push_sample(input logic [15:0] smp, input logic force_rpt);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_i       <= smp;
    force_report_i <= force_rpt;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(smp, force_rpt);
  endtask

  // Stops offering, waits for every expected event, then lets the block finish
  // any request that reports nothing.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write; the caller lowers valid after the last write of a batch.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
  endtask

  // Writes a full register set while the block is idle. The unused upper data
  // bits of the narrow registers carry noise, and sometimes a write goes to an
  // index outside the register file.
  task automatic load_config(input cfg_t c);
    drain();
    cfg_write(REG_RANGE_MAX, c.range_max);
    cfg_write(REG_RANGE_MIN, c.range_min);
    cfg_write(REG_DEAD_BAND, c.dead_band);
    cfg_write(REG_CENTER_POINT, c.center_point);
    cfg_write(REG_TRIGGER_MODE, {15'($urandom), c.trigger_mode});
    cfg_write(REG_AXIS_ID, {8'($urandom), c.axis_id});
    if ($urandom_range(0, 2) == 0)
      cfg_write($urandom_range(0, 1) ? REG_UNUSED_LO : REG_UNUSED_HI, 16'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register sets of several shapes: fully random, ordered, inverted, extremes,
  // flat span, and a wide deadzone.
  function automatic cfg_t pick_config(int unsigned shape);
    cfg_t        c;
    logic [15:0] a, b, lo, hi;
    a  = 16'($urandom);
    b  = 16'($urandom);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    c.trigger_mode = 1'($urandom);
    c.axis_id      = 8'($urandom);
    c.center_point = 16'($urandom_range(lo, hi));
    c.dead_band    = 16'($urandom_range(0, 2000));
    case (shape)
      0: begin
        c.range_max    = a;
        c.range_min    = b;
        c.dead_band    = 16'($urandom);
        c.center_point = 16'($urandom);
      end
      1: begin
        c.range_max = hi;
        c.range_min = lo;
      end
      2: begin
        c.range_max = lo;
        c.range_min = hi;
      end
      3: begin
        c.range_max    = $urandom_range(0, 1) ? FULL_SCALE : 16'd0;
        c.range_min    = $urandom_range(0, 1) ? FULL_SCALE : 16'd0;
        c.dead_band    = $urandom_range(0, 2) == 0 ? FULL_SCALE : 16'($urandom_range(0, 1));
        c.center_point = $urandom_range(0, 1) ? HALF_SCALE
                         : ($urandom_range(0, 1) ? FULL_SCALE : 16'd0);
      end
      4: begin
        c.range_max    = a;
        c.range_min    = a;
        c.center_point = $urandom_range(0, 1) ? a : b;
        c.dead_band    = 16'($urandom_range(0, 1) ? 0 : $urandom_range(0, 300));
      end
      default: begin
        c.range_max = hi;
        c.range_min = lo;
        c.dead_band = 16'($urandom_range(0, 40000));
      end
    endcase
    return c;
  endfunction

  // Samples aimed at the interesting points of the current setting: repeats of the
  // remembered sample, the deadzone edges, both range ends, and anything at all.
  function automatic logic [15:0] pick_sample(cfg_t c, logic [15:0] prev);
    int          base, off, r;
    r   = $urandom_range(0, 99);
    off = $urandom_range(0, 1) ? ($urandom_range(0, 6) - 3) : ($urandom_range(0, 128) - 64);
    if (r < 15) return prev;
    if (r < 40)
      base = $urandom_range(0, 1) ? int'(c.center_point) + int'(c.dead_band)
                                  : int'(c.center_point) - int'(c.dead_band);
    else if (r < 55)
      base = $urandom_range(0, 1) ? int'(c.range_min) + int'(c.dead_band)
                                  : int'(c.range_min) - int'(c.dead_band);
    else if (r < 75)
      base = $urandom_range(0, 1) ? int'(c.range_max) : int'(c.range_min);
    else
      return 16'($urandom);
    return 16'(base + off);
  endfunction

  initial begin : main_proc
    cfg_t c;
    in_valid_i     = 1'b0;
    sample_i       = '0;
    force_report_i = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings, centered axis. A first sample of zero matches the cleared
    // memory and reports nothing; forcing it reports. Then both ends, the center,
    // an unchanged center without and with force, and just past the center.
    push_sample(16'd0, 1'b0);
    push_sample(16'd0, 1'b1);
    push_sample(16'd65535, 1'b0);
    push_sample(16'd32767, 1'b0);
    push_sample(16'd32767, 1'b0);
    push_sample(16'd32767, 1'b1);
    push_sample(16'd32768, 1'b0);

    // Trigger with a rest deadzone: at rest, inside the deadzone, on its edge,
    // at full deflection and beyond it.
    c = '{range_max: 16'd60000, range_min: 16'd1000, dead_band: 16'd500,
          center_point: HALF_SCALE, trigger_mode: 1'b1, axis_id: 8'hFF};
    load_config(c);
    push_sample(16'd0, 1'b0);
    push_sample(16'd1499, 1'b0);
    push_sample(16'd1500, 1'b0);
    push_sample(16'd60000, 1'b0);
    push_sample(16'd65535, 1'b0);

    // Trigger with an inverted range.
    c = '{range_max: 16'd1000, range_min: 16'd60000, dead_band: 16'd500,
          center_point: HALF_SCALE, trigger_mode: 1'b1, axis_id: 8'h01};
    load_config(c);
    push_sample(16'd65535, 1'b0);
    push_sample(16'd59500, 1'b0);
    push_sample(16'd1000, 1'b0);
    push_sample(16'd0, 1'b0);
    push_sample(16'd30000, 1'b0);

    // Centered axis with an inverted range and a central deadzone, including a
    // sample exactly one deadzone width below the center.
    c = '{range_max: 16'd0, range_min: 16'd65535, dead_band: 16'd1000,
          center_point: HALF_SCALE, trigger_mode: 1'b0, axis_id: 8'hA5};
    load_config(c);
    push_sample(16'd0, 1'b0);
    push_sample(16'd65535, 1'b0);
    push_sample(16'd32000, 1'b0);
    push_sample(16'd31767, 1'b0);
    push_sample(16'd33767, 1'b0);

    // Flat spans: each axis half, then a trigger.
    c = '{range_max: HALF_SCALE, range_min: HALF_SCALE, dead_band: 16'd0,
          center_point: HALF_SCALE, trigger_mode: 1'b0, axis_id: 8'h5A};
    load_config(c);
    push_sample(16'd100, 1'b0);
    push_sample(16'd40000, 1'b0);
    c = '{range_max: 16'd5000, range_min: 16'd5000, dead_band: 16'd0,
          center_point: HALF_SCALE, trigger_mode: 1'b1, axis_id: 8'h3C};
    load_config(c);
    push_sample(16'd6000, 1'b0);

    // Random phases, each with its own register set and idle pattern.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      c = pick_config(ph < 6 ? ph : $urandom_range(0, 5));
      load_config(c);
      src_calm  = ($urandom_range(0, 3) == 0) || (ph == 3);
      sink_calm = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 0; k < PHASE_ITEMS; k++) begin
        // One long receiver hold-off while requests keep coming.
        if (ph == 3 && k == 10) hold_sink = 1'b1;
        // One sender pause until every pending event is out.
        if (ph == 5 && k == 25) drain();
        push_sample(pick_sample(c, sb.last_sample), $urandom_range(0, 4) == 0);
      end
    end

    drain();
    if (sb.failures == 0)
      $display("axis_deadzone_calibrator verification clean");
    else
      $display("axis_deadzone_calibrator verification failed");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/adc_pkg.sv
rtl/adc_map_setup.sv
rtl/adc_divider.sv
rtl/axis_deadzone_calibrator.sv
tb/tb_axis_deadzone_calibrator.sv
